FILE: design/input_event_router_with_pointer_macros.svh
// ----------------------------------------------------------------------------
// Input event router - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_ROUTER_WITH_POINTER_MACROS_SVH
`define INPUT_EVENT_ROUTER_WITH_POINTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define IER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ier_pkg.sv
// ----------------------------------------------------------------------------
// Input event router - package
// Command and register codes, fixed event codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ier_pkg;

    // Command codes
    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP_KEY   = 3'd1;
    localparam logic [2:0] CMD_POP_MOUSE = 3'd2;
    localparam logic [2:0] CMD_POP_ANY   = 3'd3;
    localparam logic [2:0] CMD_RECENTER  = 3'd4;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SIZE_W      = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_TYPE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REL_TYPE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ABS_TYPE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_TYPE   = 3'd5;

    // Fixed event codes
    localparam logic [15:0] BUTTON_CODE    = 16'h0110;
    localparam logic [15:0] MOUSE_CODE_MIN = 16'h0100;
    localparam logic [15:0] AXIS_X         = 16'd0;
    localparam logic [15:0] AXIS_Y         = 16'd1;

    // Absolute scaling: value * size / 32768, truncated toward zero
    localparam int ABS_SHIFT = 15;
    localparam int ABS_ROUND = 32767;

    // One stored event
    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
    } ier_event_t;

    // Pointer update controls, valid in the finishing cycle only
    typedef struct packed {
        logic abs_x;
        logic abs_y;
        logic rel_x;
        logic rel_y;
        logic button;
        logic clamp;
        logic recenter;
    } ier_ptr_op_t;

endpackage

`default_nettype wire

FILE: design/ier_if.sv
// ----------------------------------------------------------------------------
// Input event router - channel interfaces
// Command, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ier_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] in_type;
    logic [15:0] in_code;
    logic [31:0] in_value;

    modport source (output valid, command, in_type, in_code, in_value, input ready);
    modport sink   (input valid, command, in_type, in_code, in_value, output ready);
endinterface

interface ier_res_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic                  to_mouse_queue;
    logic [15:0]           out_type;
    logic [15:0]           out_code;
    logic [31:0]           out_value;
    logic [COORD_BITS-1:0] pointer_x;
    logic [COORD_BITS-1:0] pointer_y;
    logic [31:0]           pointer_buttons;

    modport source (output valid, accepted, to_mouse_queue, out_type, out_code, out_value,
                    pointer_x, pointer_y, pointer_buttons, input ready);
    modport sink   (input valid, accepted, to_mouse_queue, out_type, out_code, out_value,
                    pointer_x, pointer_y, pointer_buttons, output ready);
endinterface

interface ier_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ier_pkg::CFG_INDEX_W-1:0] index;
    logic [ier_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/ier_ring.sv
// ----------------------------------------------------------------------------
// Input event router - event ring
// One ring of events in a synchronous memory; holds DEPTH-1 words at most.
// The word at the read index is registered every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ier_ring #(
    parameter int DEPTH = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                pop,
    input  wire ier_pkg::ier_event_t wdata,
    output ier_pkg::ier_event_t      rdata,
    output logic                     empty,
    output logic                     full
);

    localparam int IW = $clog2(DEPTH);

    ier_pkg::ier_event_t mem [DEPTH];
    ier_pkg::ier_event_t rdata_reg;
    logic [IW-1:0]       wr_idx_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [IW-1:0]       wr_idx_next;
    logic [IW-1:0]       rd_idx_next;

    // wrap at DEPTH-1, depth need not be a power of two
    assign wr_idx_next = (wr_idx_reg == IW'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_next = (rd_idx_reg == IW'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;

    assign empty = (rd_idx_reg == wr_idx_reg);
    assign full  = (wr_idx_next == rd_idx_reg);
    assign rdata = rdata_reg;

    // memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_idx_reg] <= wdata;
        end
        rdata_reg <= mem[rd_idx_reg];
    end

    // indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_idx_reg <= wr_idx_next;
            end
            if (pop)
            begin
                rd_idx_reg <= rd_idx_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/ier_pointer.sv
// ----------------------------------------------------------------------------
// Input event router - pointer tracker
// Holds pointer position and button level; scales absolute positions,
// adds relative motion, clamps to the screen and recentres.
// ----------------------------------------------------------------------------
`default_nettype none

module ier_pointer #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [31:0]           mul_value,
    input  wire logic [COORD_BITS:0]   mul_size,
    input  wire ier_pkg::ier_ptr_op_t  op,
    input  wire logic [31:0]           value,
    input  wire logic [COORD_BITS:0]   eff_w,
    input  wire logic [COORD_BITS:0]   eff_h,
    output logic [COORD_BITS-1:0]      cursor_x,
    output logic [COORD_BITS-1:0]      cursor_y,
    output logic [31:0]                button_level
);

    localparam int PW = COORD_BITS + 34;

    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   bias;
    logic signed [PW-1:0]   biased;
    logic signed [PW-1:0]   scaled;
    logic signed [PW-1:0]   val_ext;
    logic signed [PW-1:0]   cur_x_ext;
    logic signed [PW-1:0]   cur_y_ext;
    logic signed [PW-1:0]   x_sel;
    logic signed [PW-1:0]   y_sel;
    logic [COORD_BITS-1:0]  cursor_x_reg;
    logic [COORD_BITS-1:0]  cursor_y_reg;
    logic [COORD_BITS-1:0]  cursor_x_next;
    logic [COORD_BITS-1:0]  cursor_y_next;
    logic [31:0]            button_reg;
    logic [31:0]            button_next;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [PW-1:0] v,
        input logic [COORD_BITS:0]  size
    );
        logic [PW-1:0]         size_ext;
        logic [COORD_BITS:0]   top;
        size_ext = PW'(size);
        top      = size - 1'b1;
        if (v[PW-1])
        begin
            return '0;
        end
        else if ($unsigned(v) >= size_ext)
        begin
            return top[COORD_BITS-1:0];
        end
        else
        begin
            return v[COORD_BITS-1:0];
        end
    endfunction

    // scale product, taken when the word is accepted
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PW'($signed(mul_value)) * PW'($signed({1'b0, mul_size}));
        end
    end

    // divide by 32768 rounding toward zero
    assign bias   = prod_reg[PW-1] ? PW'(ier_pkg::ABS_ROUND) : '0;
    assign biased = prod_reg + bias;
    assign scaled = biased >>> ier_pkg::ABS_SHIFT;

    // relative motion
    assign val_ext   = PW'($signed(value));
    assign cur_x_ext = $signed(PW'(cursor_x_reg));
    assign cur_y_ext = $signed(PW'(cursor_y_reg));

    assign x_sel = op.abs_x ? scaled : (op.rel_x ? cur_x_ext + val_ext : cur_x_ext);
    assign y_sel = op.abs_y ? scaled : (op.rel_y ? cur_y_ext + val_ext : cur_y_ext);

    // next pointer state
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (op.recenter)
        begin
            cursor_x_next = COORD_BITS'(eff_w >> 1);
            cursor_y_next = COORD_BITS'(eff_h >> 1);
        end
        else if (op.clamp)
        begin
            cursor_x_next = clamp_axis(x_sel, eff_w);
            cursor_y_next = clamp_axis(y_sel, eff_h);
        end
        button_next = op.button ? value : button_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            button_reg   <= '0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            button_reg   <= button_next;
        end
    end

    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign button_level = button_reg;

endmodule

`default_nettype wire

FILE: design/input_event_router_with_pointer.sv
// ----------------------------------------------------------------------------
// Input event router with pointer
// Routes input events into a key ring and a mouse ring and tracks the pointer.
// ----------------------------------------------------------------------------
// Each command word is handled in an accept cycle and an execute state: in
// the accept cycle the word is registered, the absolute scale product is
// formed and both rings register the word at their read index; in the execute
// state the pointer is updated, the selected ring is written or popped and the
// result word is loaded into the output register. The registered read port of
// the ring memories sets this sequence. A result that is not taken holds the
// next word in the execute state. Each ring holds QUEUE_DEPTH-1 words; the ring
// memories need no clearing after reset. Configuration writes are taken at any time.
`default_nettype none

`include "input_event_router_with_pointer_macros.svh"

module input_event_router_with_pointer #(
    parameter int QUEUE_DEPTH = 256,
    parameter int COORD_BITS  = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ier_cmd_if.sink   request,
    ier_res_if.source result,
    ier_cfg_if.sink   cfg
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;

    // configuration
    logic [ier_pkg::SIZE_W-1:0] screen_width_reg;
    logic [ier_pkg::SIZE_W-1:0] screen_height_reg;
    logic [15:0]                key_type_reg;
    logic [15:0]                rel_type_reg;
    logic [15:0]                abs_type_reg;
    logic [15:0]                button_type_reg;

    // held command word
    logic [2:0]  cmd_reg;
    logic [15:0] type_reg;
    logic [15:0] code_reg;
    logic [31:0] value_reg;

    // result register
    logic                res_valid_reg;
    logic                res_accepted_reg;
    logic                res_to_mouse_reg;
    ier_pkg::ier_event_t res_event_reg;
    logic                acc_next;
    logic                to_mouse_next;
    ier_pkg::ier_event_t event_next;

    logic                  accept;
    logic                  finish;
    logic [COORD_BITS:0]   eff_w;
    logic [COORD_BITS:0]   eff_h;
    logic                  is_abs;
    logic                  is_rel;
    logic                  is_key;
    logic                  route_key;
    logic                  is_push;
    ier_pkg::ier_ptr_op_t  ptr_op;
    ier_pkg::ier_event_t   wdata;
    ier_pkg::ier_event_t   key_rdata;
    ier_pkg::ier_event_t   mouse_rdata;
    logic                  key_push;
    logic                  key_pop;
    logic                  key_empty;
    logic                  key_full;
    logic                  mouse_push;
    logic                  mouse_pop;
    logic                  mouse_empty;
    logic                  mouse_full;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [31:0]           button_level;

    // screen size limited to 1 .. 2^COORD_BITS
    function automatic logic [COORD_BITS:0] eff_size(input logic [ier_pkg::SIZE_W-1:0] s);
        logic [31:0] s_ext;
        logic [31:0] lim;
        s_ext = 32'(s);
        lim   = 32'(1) << COORD_BITS;
        if (s_ext == '0)
        begin
            return (COORD_BITS + 1)'(1);
        end
        else if (s_ext > lim)
        begin
            return (COORD_BITS + 1)'(lim);
        end
        else
        begin
            return (COORD_BITS + 1)'(s_ext);
        end
    endfunction

    assign eff_w = eff_size(screen_width_reg);
    assign eff_h = eff_size(screen_height_reg);

    // handshakes
    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign finish        = (state_reg == ST_EXEC) && (!res_valid_reg || result.ready);
    assign cfg.ready     = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= ier_pkg::SIZE_W'(800);
            screen_height_reg <= ier_pkg::SIZE_W'(600);
            key_type_reg      <= 16'd1;
            rel_type_reg      <= 16'd2;
            abs_type_reg      <= 16'd3;
            button_type_reg   <= 16'd16;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ier_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg.data[ier_pkg::SIZE_W-1:0];
                ier_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg.data[ier_pkg::SIZE_W-1:0];
                ier_pkg::REG_KEY_TYPE:      key_type_reg      <= cfg.data;
                ier_pkg::REG_REL_TYPE:      rel_type_reg      <= cfg.data;
                ier_pkg::REG_ABS_TYPE:      abs_type_reg      <= cfg.data;
                ier_pkg::REG_BUTTON_TYPE:   button_type_reg   <= cfg.data;
                default:                    ;
            endcase
        end
    end

    // command word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= request.command;
            type_reg  <= request.in_type;
            code_reg  <= request.in_code;
            value_reg <= request.in_value;
        end
    end

    // event decode
    assign is_push   = (cmd_reg == ier_pkg::CMD_PUSH);
    assign is_abs    = (type_reg == abs_type_reg);
    assign is_rel    = !is_abs && (type_reg == rel_type_reg);
    assign is_key    = (type_reg == key_type_reg);
    assign route_key = is_key && (code_reg < ier_pkg::MOUSE_CODE_MIN);

    always_comb
    begin
        ptr_op          = '0;
        ptr_op.abs_x    = finish && is_push && is_abs && (code_reg == ier_pkg::AXIS_X);
        ptr_op.abs_y    = finish && is_push && is_abs && (code_reg == ier_pkg::AXIS_Y);
        ptr_op.rel_x    = finish && is_push && is_rel && (code_reg == ier_pkg::AXIS_X);
        ptr_op.rel_y    = finish && is_push && is_rel && (code_reg == ier_pkg::AXIS_Y);
        ptr_op.button   = finish && is_push && !is_abs && !is_rel && is_key
                          && (code_reg == ier_pkg::BUTTON_CODE);
        ptr_op.clamp    = finish && is_push;
        ptr_op.recenter = finish && (cmd_reg == ier_pkg::CMD_RECENTER);
    end

    // pushed word; keys routed to the mouse ring are retyped
    assign wdata.ev_type  = (is_key && !route_key) ? button_type_reg : type_reg;
    assign wdata.ev_code  = code_reg;
    assign wdata.ev_value = value_reg;

    // ring strobes
    assign key_push   = finish && is_push && route_key && !key_full;
    assign mouse_push = finish && is_push && !route_key && !mouse_full;
    assign key_pop    = finish && !key_empty
                        && ((cmd_reg == ier_pkg::CMD_POP_KEY) || (cmd_reg == ier_pkg::CMD_POP_ANY));
    assign mouse_pop  = finish && !mouse_empty
                        && ((cmd_reg == ier_pkg::CMD_POP_MOUSE)
                            || ((cmd_reg == ier_pkg::CMD_POP_ANY) && key_empty));

    // result word
    always_comb
    begin
        acc_next      = 1'b0;
        to_mouse_next = 1'b0;
        event_next    = '0;
        case (cmd_reg)
            ier_pkg::CMD_PUSH:
            begin
                to_mouse_next = !route_key;
                acc_next      = route_key ? !key_full : !mouse_full;
            end
            ier_pkg::CMD_POP_KEY:
            begin
                acc_next   = !key_empty;
                event_next = key_empty ? '0 : key_rdata;
            end
            ier_pkg::CMD_POP_MOUSE:
            begin
                to_mouse_next = 1'b1;
                acc_next      = !mouse_empty;
                event_next    = mouse_empty ? '0 : mouse_rdata;
            end
            ier_pkg::CMD_POP_ANY:
            begin
                if (!key_empty)
                begin
                    acc_next   = 1'b1;
                    event_next = key_rdata;
                end
                else
                begin
                    to_mouse_next = 1'b1;
                    acc_next      = !mouse_empty;
                    event_next    = mouse_empty ? '0 : mouse_rdata;
                end
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            res_valid_reg    <= 1'b0;
            res_accepted_reg <= 1'b0;
            res_to_mouse_reg <= 1'b0;
            res_event_reg    <= '0;
        end
        else
        begin
            // a new result word replaces the one taken in the same cycle
            if (finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (finish)
                    begin
                        state_reg        <= ST_IDLE;
                        res_accepted_reg <= acc_next;
                        res_to_mouse_reg <= to_mouse_next;
                        res_event_reg    <= event_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // rings
    ier_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_key_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (key_push),
        .pop   (key_pop),
        .wdata (wdata),
        .rdata (key_rdata),
        .empty (key_empty),
        .full  (key_full)
    );

    ier_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mouse_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mouse_push),
        .pop   (mouse_pop),
        .wdata (wdata),
        .rdata (mouse_rdata),
        .empty (mouse_empty),
        .full  (mouse_full)
    );

    // pointer; the product uses the height only for axis y
    ier_pointer #(
        .COORD_BITS (COORD_BITS)
    ) u_pointer (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .mul_value    (request.in_value),
        .mul_size     ((request.in_code == ier_pkg::AXIS_Y) ? eff_h : eff_w),
        .op           (ptr_op),
        .value        (value_reg),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .button_level (button_level)
    );

    // result port; pointer state only moves when a result is loaded
    assign result.valid           = res_valid_reg;
    assign result.accepted        = res_accepted_reg;
    assign result.to_mouse_queue  = res_to_mouse_reg;
    assign result.out_type        = res_event_reg.ev_type;
    assign result.out_code        = res_event_reg.ev_code;
    assign result.out_value       = res_event_reg.ev_value;
    assign result.pointer_x       = cursor_x;
    assign result.pointer_y       = cursor_y;
    assign result.pointer_buttons = button_level;

    // checks
    `IER_ASSERT_NEXT(a_one_word_in_flight, clk, rst_n, accept, !request.ready,
        "word accepted while previous word still in flight")
    `IER_ASSERT_NOW(a_empty_result_zero, clk, rst_n, res_valid_reg && !res_accepted_reg,
        res_event_reg == '0, "result without an event carries nonzero event fields")
    `IER_ASSERT_NOW(a_ring_state, clk, rst_n, key_empty || mouse_empty || 1'b1,
        !(key_empty && key_full) && !(mouse_empty && mouse_full),
        "ring reports empty and full at once")

endmodule

`default_nettype wire
